### hw/rtl/tsf_pkg.sv
// ----------------------------------------------------------------------------
// Touch sample filter package
// Shared widths, register indexes, reset values and payload types for the
// touch sample filter and press tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsf_pkg;

  // Field widths.
  localparam int ADC_W     = 12;
  localparam int COORD_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int ERR_W     = 12;
  localparam int GRP_W     = 2;
  localparam int FRAC_BITS = 14;

  localparam int ADC_MAX = (1 << ADC_W) - 1;

  // Default filter geometry.
  localparam int SAMPLES_PER_GROUP_DEF = 5;
  localparam int TRIM_EACH_END_DEF     = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_RANGE = 3'd4;

  // Configuration reset values.
  localparam logic signed [CFG_W-1:0] X_GAIN_RST   = 16'sd1081;
  localparam logic signed [CFG_W-1:0] Y_GAIN_RST   = 16'sd1442;
  localparam logic signed [CFG_W-1:0] X_OFFSET_RST = -16'sd15;
  localparam logic signed [CFG_W-1:0] Y_OFFSET_RST = -16'sd18;
  localparam logic [ERR_W-1:0]        ERR_RST      = 12'd50;

  // Coordinate value shown while the pen stays up.
  localparam logic [COORD_W-1:0] COORD_IDLE = 16'hFFFF;

  // Group order within one scan.
  localparam logic [GRP_W-1:0] GRP_X0 = 2'd0;
  localparam logic [GRP_W-1:0] GRP_Y0 = 2'd1;
  localparam logic [GRP_W-1:0] GRP_X1 = 2'd2;
  localparam logic [GRP_W-1:0] GRP_Y1 = 2'd3;

  typedef struct packed {
    logic             func;
    logic [ADC_W-1:0] sample;
    logic             raw_mode;
    logic             clear_caught;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic               pressed;
    logic               caught;
    logic               reading_ok;
  } out_item_t;

  // Group completion event from the accumulator.
  typedef struct packed {
    logic             done;
    logic [GRP_W-1:0] grp;
  } grp_evt_t;

  // Trim per end, limited so that at least one sample is averaged.
  function automatic int eff_trim(int n, int t);
    int lim;
    lim = (n - 1) / 2;
    return (t > lim) ? lim : t;
  endfunction

  // Width of a running sum over one group.
  function automatic int sum_width(int n);
    return $clog2(n * ADC_MAX + 1);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tsf_trim_acc.sv
// ----------------------------------------------------------------------------
// Trimmed group accumulator
// Counts samples into groups, keeps a running sum and the smallest and
// largest samples of the group, and gives the trimmed sum on the last one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsf_trim_acc #(
  parameter int SAMPLES_PER_GROUP = tsf_pkg::SAMPLES_PER_GROUP_DEF,
  parameter int TRIM_EACH_END     = tsf_pkg::TRIM_EACH_END_DEF,
  localparam int SumW             = tsf_pkg::sum_width(SAMPLES_PER_GROUP)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step,
  input  wire logic                     func,
  input  wire logic [tsf_pkg::ADC_W-1:0] sample,
  output tsf_pkg::grp_evt_t             evt,
  output logic [SumW-1:0]               trim_sum
);

  import tsf_pkg::*;

  localparam int EffTrim = eff_trim(SAMPLES_PER_GROUP, TRIM_EACH_END);
  localparam int PosW    = $clog2(SAMPLES_PER_GROUP);
  localparam logic [PosW-1:0] PosLast = PosW'(SAMPLES_PER_GROUP - 1);

  logic [PosW-1:0]  pos_r, pos_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic [SumW-1:0]  sum_r, sum_nxt;
  logic [ADC_W-1:0] lo1_r, lo2_r, hi1_r, hi2_r;
  logic [ADC_W-1:0] lo1_nxt, lo2_nxt, hi1_nxt, hi2_nxt;
  logic             first, last;

  assign first = (pos_r == '0);
  assign last  = (pos_r == PosLast);

  // Running sum and the two smallest and two largest samples, this one included.
  always_comb begin
    sum_nxt = (first ? '0 : sum_r) + SumW'(sample);
    if (first) begin
      lo1_nxt = sample;
      lo2_nxt = ADC_W'(ADC_MAX);
      hi1_nxt = sample;
      hi2_nxt = '0;
    end else begin
      lo1_nxt = lo1_r;
      lo2_nxt = lo2_r;
      hi1_nxt = hi1_r;
      hi2_nxt = hi2_r;
      if (sample < lo1_r) begin
        lo1_nxt = sample;
        lo2_nxt = lo1_r;
      end else if (sample < lo2_r) begin
        lo2_nxt = sample;
      end
      if (sample > hi1_r) begin
        hi1_nxt = sample;
        hi2_nxt = hi1_r;
      end else if (sample > hi2_r) begin
        hi2_nxt = sample;
      end
    end
  end

  // Trimmed sum, valid in the cycle of the group's last sample.
  always_comb begin
    if (EffTrim == 0) begin
      trim_sum = sum_nxt;
    end else if (EffTrim == 1) begin
      trim_sum = sum_nxt - SumW'(lo1_nxt) - SumW'(hi1_nxt);
    end else begin
      trim_sum = sum_nxt - SumW'(lo1_nxt) - SumW'(lo2_nxt)
               - SumW'(hi1_nxt) - SumW'(hi2_nxt);
    end
  end

  assign evt.done = step && func && last;
  assign evt.grp  = grp_r;

  // Position counters; a pen-up item drops a partial scan.
  always_comb begin
    pos_nxt = pos_r;
    grp_nxt = grp_r;
    if (step) begin
      if (func) begin
        pos_nxt = last ? '0 : pos_r + PosW'(1);
        grp_nxt = last ? grp_r + GRP_W'(1) : grp_r;
      end else begin
        pos_nxt = '0;
        grp_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      grp_r <= '0;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      grp_r <= grp_nxt;
      if (step && func) begin
        sum_r <= sum_nxt;
      end
    end
  end

  // Extremes need no reset: the first sample of a group overwrites them.
  always_ff @(posedge clk) begin
    if (step && func) begin
      lo1_r <= lo1_nxt;
      lo2_r <= lo2_nxt;
      hi1_r <= hi1_nxt;
      hi2_r <= hi2_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/touch_sample_filter_and_press_tracker_core.sv
// ----------------------------------------------------------------------------
// Touch sample filter and press tracker
// Filters touch ADC samples into trimmed group means, checks that the two
// readings of each axis agree, maps them to screen coordinates and tracks
// the pen press state.
//
//   Channel  Ports                         Moves
//   input    in_valid/in_ready/in_data     one sample or pen-up event
//   result   out_valid/out_ready/out_data  one scan or pen-up report
//   config   cfg_we/cfg_idx/cfg_wdata      one register write, no wait
//
// One item is taken per cycle unless every stage is full behind a stalled result;
// the item that causes a result passes through the input register, trimmed
// sum, reciprocal divide, axis check and gain multiply, offset and press state.
// Reset is synchronous and needs no clearing pass. A stalled result holds
// only the last stage; empty stages ahead of it keep taking items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module touch_sample_filter_and_press_tracker_core #(
  parameter int SAMPLES_PER_GROUP = tsf_pkg::SAMPLES_PER_GROUP_DEF,
  parameter int TRIM_EACH_END     = tsf_pkg::TRIM_EACH_END_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire tsf_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output tsf_pkg::out_item_t               out_data,
  input  wire logic                        cfg_we,
  input  wire logic [tsf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [tsf_pkg::CFG_W-1:0]   cfg_wdata
);

  import tsf_pkg::*;

  localparam int EffTrim  = eff_trim(SAMPLES_PER_GROUP, TRIM_EACH_END);
  localparam int SumW     = sum_width(SAMPLES_PER_GROUP);
  localparam int Div      = SAMPLES_PER_GROUP - 2 * EffTrim;
  localparam int RecShift = SumW + $clog2(Div);
  localparam int RecMul   = ((1 << RecShift) + Div - 1) / Div;
  localparam int RecW     = SumW + 2;
  localparam int ProdW    = CFG_W + ADC_W + 1;
  localparam int QuotW    = ProdW - FRAC_BITS;
  localparam logic [RecW-1:0] RecMulV = RecW'(RecMul);

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_GROUP,
    KIND_PEN_UP
  } kind_t;

  // Configuration registers.
  logic signed [CFG_W-1:0] x_gain_r, y_gain_r, x_off_r, y_off_r;
  logic [ERR_W-1:0]        err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_gain_r <= X_GAIN_RST;
      y_gain_r <= Y_GAIN_RST;
      x_off_r  <= X_OFFSET_RST;
      y_off_r  <= Y_OFFSET_RST;
      err_r    <= ERR_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_X_GAIN:    x_gain_r <= cfg_wdata;
        CFG_Y_GAIN:    y_gain_r <= cfg_wdata;
        CFG_X_OFFSET:  x_off_r  <= cfg_wdata;
        CFG_Y_OFFSET:  y_off_r  <= cfg_wdata;
        CFG_ERR_RANGE: err_r    <= cfg_wdata[ERR_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage registers.
  logic                    s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  in_item_t                s1_item_r;
  kind_t                   s1_kind, s2_kind_r, s3_kind_r, s3_kind_nxt, s4_kind_r;
  logic [GRP_W-1:0]        s2_grp_r, s3_grp_r;
  logic [SumW-1:0]         s2_tsum_r;
  logic [ADC_W-1:0]        s3_mean_r;
  logic                    s2_raw_r, s3_raw_r, s4_raw_r;
  logic                    s2_clr_r, s3_clr_r, s4_clr_r;
  logic                    s4_ok_r;
  logic [ADC_W-1:0]        s4_ax_r, s4_ay_r;
  logic signed [ProdW-1:0] s4_px_r, s4_py_r;

  // Handshake chain: a stage moves on when the next one can take it.
  logic out_free, s4_res, go1, go2, go3, go4, rdy2, rdy3, rdy4;

  assign out_free = !out_valid || out_ready;
  assign s4_res   = (s4_kind_r != KIND_SAMPLE);
  assign go4      = s4_v_r && (!s4_res || out_free);
  assign rdy4     = !s4_v_r || go4;
  assign go3      = s3_v_r && rdy4;
  assign rdy3     = !s3_v_r || go3;
  assign go2      = s2_v_r && rdy3;
  assign rdy2     = !s2_v_r || go2;
  assign go1      = s1_v_r && rdy2;
  assign in_ready = !s1_v_r || go1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (in_ready) s1_v_r <= in_valid;
      if (rdy2)     s2_v_r <= go1;
      if (rdy3)     s3_v_r <= go2;
      if (rdy4)     s4_v_r <= go3;
    end
  end

  // Stage 1: input register.
  always_ff @(posedge clk) begin
    if (in_ready) s1_item_r <= in_data;
  end

  // Group accumulation on the transfer out of stage 1.
  grp_evt_t        evt;
  logic [SumW-1:0] trim_sum;

  tsf_trim_acc #(
    .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP),
    .TRIM_EACH_END    (TRIM_EACH_END)
  ) u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (go1),
    .func    (s1_item_r.func),
    .sample  (s1_item_r.sample),
    .evt     (evt),
    .trim_sum(trim_sum)
  );

  always_comb begin
    if (!s1_item_r.func) begin
      s1_kind = KIND_PEN_UP;
    end else if (evt.done) begin
      s1_kind = KIND_GROUP;
    end else begin
      s1_kind = KIND_SAMPLE;
    end
  end

  // Stage 2: trimmed sum.
  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_kind_r <= s1_kind;
      s2_grp_r  <= evt.grp;
      s2_tsum_r <= trim_sum;
      s2_raw_r  <= s1_item_r.raw_mode;
      s2_clr_r  <= s1_item_r.clear_caught;
    end
  end

  // Floor division by the kept sample count through an exact reciprocal.
  logic [SumW+RecW-1:0] rec_prod;
  assign rec_prod = s2_tsum_r * RecMulV;

  // Stage 3: group mean.
  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_kind_r <= s2_kind_r;
      s3_grp_r  <= s2_grp_r;
      s3_mean_r <= rec_prod[RecShift +: ADC_W];
      s3_raw_r  <= s2_raw_r;
      s3_clr_r  <= s2_clr_r;
    end
  end

  // Means of the earlier groups of a scan.
  logic [ADC_W-1:0] fx_r, fy_r, sx_r;

  always_ff @(posedge clk) begin
    if (go3 && s3_kind_r == KIND_GROUP) begin
      case (s3_grp_r)
        GRP_X0:  fx_r <= s3_mean_r;
        GRP_Y0:  fy_r <= s3_mean_r;
        GRP_X1:  sx_r <= s3_mean_r;
        default: ;
      endcase
    end
  end

  // Axis agreement, pair averages and the gain products on the scan end.
  logic [ADC_W-1:0]        dx, dy, ax, ay;
  logic [ADC_W:0]          sum_x, sum_y;
  logic                    ok;
  logic signed [ProdW-1:0] px, py;

  always_comb begin
    dx    = (fx_r >= sx_r) ? fx_r - sx_r : sx_r - fx_r;
    dy    = (fy_r >= s3_mean_r) ? fy_r - s3_mean_r : s3_mean_r - fy_r;
    ok    = (dx < err_r) && (dy < err_r);
    sum_x = {1'b0, fx_r} + {1'b0, sx_r};
    sum_y = {1'b0, fy_r} + {1'b0, s3_mean_r};
    ax    = sum_x[ADC_W:1];
    ay    = sum_y[ADC_W:1];
    px    = x_gain_r * $signed({1'b0, ax});
    py    = y_gain_r * $signed({1'b0, ay});
    // Only the last group of a scan travels on as a group event.
    if (s3_kind_r == KIND_GROUP && s3_grp_r != GRP_Y1) begin
      s3_kind_nxt = KIND_SAMPLE;
    end else begin
      s3_kind_nxt = s3_kind_r;
    end
  end

  // Stage 4: products and check result.
  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_kind_r <= s3_kind_nxt;
      s4_ok_r   <= ok;
      s4_raw_r  <= s3_raw_r;
      s4_clr_r  <= s3_clr_r;
      s4_ax_r   <= ax;
      s4_ay_r   <= ay;
      s4_px_r   <= px;
      s4_py_r   <= py;
    end
  end

  // Calibration: floor by the Q2.14 scale, add the offset, keep 16 bits.
  logic signed [QuotW-1:0] qx, qy;
  logic [COORD_W-1:0]      map_x, map_y, new_x, new_y;

  always_comb begin
    qx    = s4_px_r[ProdW-1:FRAC_BITS];
    qy    = s4_py_r[ProdW-1:FRAC_BITS];
    map_x = COORD_W'(qx) + COORD_W'(x_off_r);
    map_y = COORD_W'(qy) + COORD_W'(y_off_r);
    if (!s4_ok_r) begin
      new_x = 'x;
      new_y = 'x;
    end else if (s4_raw_r) begin
      new_x = COORD_W'(s4_ax_r);
      new_y = COORD_W'(s4_ay_r);
    end else begin
      new_x = map_x;
      new_y = map_y;
    end
  end

  // Press state.
  logic               pressed_r, pressed_nxt, caught_r, caught_nxt;
  logic [COORD_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_W-1:0] press_x_r, press_x_nxt, press_y_r, press_y_nxt;

  always_comb begin
    pressed_nxt = pressed_r;
    caught_nxt  = caught_r && !s4_clr_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    press_x_nxt = press_x_r;
    press_y_nxt = press_y_r;
    case (s4_kind_r)
      KIND_GROUP: begin
        if (s4_ok_r) begin
          cur_x_nxt = new_x;
          cur_y_nxt = new_y;
        end
        if (!pressed_r) begin
          pressed_nxt = 1'b1;
          caught_nxt  = 1'b1;
          press_x_nxt = cur_x_nxt;
          press_y_nxt = cur_y_nxt;
        end
      end
      KIND_PEN_UP: begin
        if (pressed_r) begin
          pressed_nxt = 1'b0;
        end else begin
          press_x_nxt = '0;
          press_y_nxt = '0;
          cur_x_nxt   = COORD_IDLE;
          cur_y_nxt   = COORD_IDLE;
        end
      end
      default: ;
    endcase
  end

  // Press state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      caught_r  <= 1'b0;
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      press_x_r <= '0;
      press_y_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (go4) begin
        pressed_r <= pressed_nxt;
        caught_r  <= caught_nxt;
        cur_x_r   <= cur_x_nxt;
        cur_y_r   <= cur_y_nxt;
        press_x_r <= press_x_nxt;
        press_y_r <= press_y_nxt;
      end
      if (go4 && s4_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go4 && s4_res) begin
      out_data.pos_x      <= cur_x_nxt;
      out_data.pos_y      <= cur_y_nxt;
      out_data.start_x    <= press_x_nxt;
      out_data.start_y    <= press_y_nxt;
      out_data.pressed    <= pressed_nxt;
      out_data.caught     <= caught_nxt;
      out_data.reading_ok <= (s4_kind_r == KIND_GROUP) && s4_ok_r;
    end
  end

  // A completed scan always leaves the pen pressed.
  a_scan_sets_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    go4 && s4_kind_r == KIND_GROUP |=> pressed_r)
    else $error("pressed flag not set after a completed scan");

  // A good reading comes only from a scan, which leaves the pen pressed.
  a_ok_means_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reading_ok |-> out_data.pressed)
    else $error("reading_ok reported without a press");

  // Pen-up while idle parks the coordinates.
  a_idle_park: assert property (@(posedge clk) disable iff (!rst_n)
    go4 && s4_kind_r == KIND_PEN_UP && !pressed_r |=>
      cur_x_r == COORD_IDLE && cur_y_r == COORD_IDLE && press_x_r == '0)
    else $error("idle pen-up did not park the coordinates");

endmodule

`default_nettype wire

### sim/touch_sample_filter_and_press_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// Touch sample filter and press tracker testbench
// Drives pen-down sample scans, pen-up events and malformed sequences into
// the core, under several calibration and agreement settings. It predicts
// every report from its own model of the trimmed group means, the axis
// agreement check, the calibration mapping and the press state, and then
// checks each report field by field as it leaves the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_sample_filter_and_press_tracker_core_tb;

  import tsf_pkg::*;

  localparam int GROUP_LEN   = SAMPLES_PER_GROUP_DEF;
  localparam int TRIM_LEN    = TRIM_EACH_END_DEF;
  localparam int SETTLE      = 12;
  localparam int HOLD_LEN    = 300;
  localparam int QUIET_LIMIT = 3000;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Stimulus waiting to be offered, and reports waiting to be seen.
  in_item_t  sample_feed[$];
  out_item_t pending_reports[$];
  int        items_queued = 0;
  int        errors       = 0;
  bit        steady_tail  = 1'b0;

  // Calibration copy kept by the predictor.
  logic signed [CFG_W-1:0] cal_x_gain, cal_y_gain, cal_x_offset, cal_y_offset;
  logic [ERR_W-1:0]        agree_limit;

  // Scan and press state kept by the predictor.
  int                 scan_fill;
  logic [ADC_W-1:0]   group_buf [GROUP_LEN];
  logic [ADC_W-1:0]   first_x, first_y, second_x;
  logic [COORD_W-1:0] cur_x, cur_y, anchor_x, anchor_y;
  logic               pen_down, pen_caught;

  touch_sample_filter_and_press_tracker_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void reset_tracker();
    cal_x_gain   = X_GAIN_RST;
    cal_y_gain   = Y_GAIN_RST;
    cal_x_offset = X_OFFSET_RST;
    cal_y_offset = Y_OFFSET_RST;
    agree_limit  = ERR_RST;
    scan_fill    = 0;
    first_x      = '0;
    first_y      = '0;
    second_x     = '0;
    cur_x        = '0;
    cur_y        = '0;
    anchor_x     = '0;
    anchor_y     = '0;
    pen_down     = 1'b0;
    pen_caught   = 1'b0;
  endfunction

  // Sorts the group, drops the trimmed ends and floor-averages the rest.
  function automatic logic [ADC_W-1:0] trimmed_mean();
    logic [ADC_W-1:0] v [GROUP_LEN];
    logic [ADC_W-1:0] t;
    int i, j, lo, sum;
    for (i = 0; i < GROUP_LEN; i++) v[i] = group_buf[i];
    for (i = 1; i < GROUP_LEN; i++) begin
      t = v[i];
      j = i;
      while (j > 0 && v[j-1] > t) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = t;
    end
    // At least one sample always survives the trim.
    lo = (TRIM_LEN > (GROUP_LEN - 1) / 2) ? (GROUP_LEN - 1) / 2 : TRIM_LEN;
    sum = 0;
    for (i = lo; i < GROUP_LEN - lo; i++) sum += int'(v[i]);
    return ADC_W'(sum / (GROUP_LEN - 2 * lo));
  endfunction

  function automatic bit close_enough(logic [ADC_W-1:0] a, logic [ADC_W-1:0] b);
    int d;
    d = (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return d < int'(agree_limit);
  endfunction

  // Floor of gain * raw / 2^14, plus the offset, wrapped to 16 bits.
  function automatic logic [COORD_W-1:0] scale_axis(logic signed [CFG_W-1:0] g,
                                                    logic signed [CFG_W-1:0] o,
                                                    logic [ADC_W-1:0] r);
    longint p, q;
    p = longint'(g) * longint'(r);
    q = (p >>> FRAC_BITS) + longint'(o);
    return q[COORD_W-1:0];
  endfunction

  // Advances the tracker by one accepted item and queues its report, if any.
  function automatic void predict_report(in_item_t it);
    logic [ADC_W-1:0] m, ax, ay;
    logic [GRP_W-1:0] grp;
    out_item_t        rep;
    int               pos;
    bit               emit, ok;
    emit = 1'b0;
    ok   = 1'b0;
    if (it.clear_caught) pen_caught = 1'b0;
    if (it.func) begin
      pos = scan_fill % GROUP_LEN;
      grp = GRP_W'(scan_fill / GROUP_LEN);
      group_buf[pos] = it.sample;
      scan_fill++;
      if (pos == GROUP_LEN - 1) begin
        m = trimmed_mean();
        if (grp == GRP_X0) first_x = m;
        else if (grp == GRP_Y0) first_y = m;
        else if (grp == GRP_X1) second_x = m;
        else begin
          // Last group closes the scan.
          scan_fill = 0;
          emit = 1'b1;
          ok = close_enough(first_x, second_x) && close_enough(first_y, m);
          if (ok) begin
            ax = ADC_W'((int'(first_x) + int'(second_x)) / 2);
            ay = ADC_W'((int'(first_y) + int'(m)) / 2);
            if (it.raw_mode) begin
              cur_x = COORD_W'(ax);
              cur_y = COORD_W'(ay);
            end else begin
              cur_x = scale_axis(cal_x_gain, cal_x_offset, ax);
              cur_y = scale_axis(cal_y_gain, cal_y_offset, ay);
            end
          end
          // A new press latches the start point even on a failed reading.
          if (!pen_down) begin
            pen_down   = 1'b1;
            pen_caught = 1'b1;
            anchor_x   = cur_x;
            anchor_y   = cur_y;
          end
        end
      end
    end else begin
      // Pen-up drops any partial scan.
      scan_fill = 0;
      emit = 1'b1;
      if (pen_down) begin
        pen_down = 1'b0;
      end else begin
        anchor_x = '0;
        anchor_y = '0;
        cur_x    = COORD_IDLE;
        cur_y    = COORD_IDLE;
      end
    end
    if (emit) begin
      rep.pos_x      = cur_x;
      rep.pos_y      = cur_y;
      rep.start_x    = anchor_x;
      rep.start_y    = anchor_y;
      rep.pressed    = pen_down;
      rep.caught     = pen_caught;
      rep.reading_ok = ok;
      pending_reports.push_back(rep);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------

  int send_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) predict_report(in_data);
      // Offer the next item once the current one has had its transfer.
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_feed.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= sample_feed.pop_front();
          if (!steady_tail && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls and one long hold-off
  // ---------------------------------------------------------------------------

  int  reports_taken;
  int  stall_left;
  int  hold_left;
  bit  hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      reports_taken = 0;
      stall_left    = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
    end else begin
      if (out_valid && out_ready) reports_taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && reports_taken >= 20 && sample_feed.size() > 120) begin
        // Hold off while plenty of items are still being offered.
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!steady_tail && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Report checker
  // ---------------------------------------------------------------------------

  out_item_t want_rep;

  function automatic int field_diff(string name, logic [COORD_W-1:0] want,
                                    logic [COORD_W-1:0] got);
    if (want === got) return 0;
    $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ns: report with none expected, got %h", $time, out_data);
        errors++;
      end else begin
        want_rep = pending_reports.pop_front();
        errors += field_diff("pos_x", want_rep.pos_x, out_data.pos_x);
        errors += field_diff("pos_y", want_rep.pos_y, out_data.pos_y);
        errors += field_diff("start_x", want_rep.start_x, out_data.start_x);
        errors += field_diff("start_y", want_rep.start_y, out_data.start_y);
        errors += field_diff("pressed", want_rep.pressed, out_data.pressed);
        errors += field_diff("caught", want_rep.caught, out_data.caught);
        errors += field_diff("reading_ok", want_rep.reading_ok, out_data.reading_ok);
      end
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("touch_sample_filter_and_press_tracker_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_fixed(bit func, logic [ADC_W-1:0] s, bit raw, bit clr);
    in_item_t it;
    it.func         = func;
    it.sample       = s;
    it.raw_mode     = raw;
    it.clear_caught = clr;
    sample_feed.push_back(it);
    items_queued++;
  endtask

  task automatic push_item(bit func, logic [ADC_W-1:0] s);
    push_fixed(func, s, 1'($urandom), $urandom_range(0, 5) == 0);
  endtask

  // Five samples around a center, with an occasional wild outlier.
  task automatic add_group(int center, int jit);
    int k, s;
    for (k = 0; k < GROUP_LEN; k++) begin
      s = center + int'($urandom_range(0, 2 * jit)) - jit;
      if ($urandom_range(0, 7) == 0) s = $urandom_range(0, ADC_MAX);
      if (s < 0) s = 0;
      if (s > ADC_MAX) s = ADC_MAX;
      push_item(1'b1, ADC_W'(s));
    end
  endtask

  // One well-formed scan; the second reading of each axis drifts by a
  // random amount so that agreement both holds and fails.
  task automatic add_scan();
    int bx, by, dx, dy, jit;
    jit = ($urandom_range(0, 3) == 0) ? 40 : 6;
    bx = $urandom_range(0, ADC_MAX);
    by = $urandom_range(0, ADC_MAX);
    if ($urandom_range(0, 9) == 0) bx = ($urandom_range(0, 1) == 0) ? 0 : ADC_MAX;
    if ($urandom_range(0, 9) == 0) by = ($urandom_range(0, 1) == 0) ? 0 : ADC_MAX;
    case ($urandom_range(0, 3))
      0: begin dx = 0; dy = 0; end
      1: begin
        dx = int'($urandom_range(0, 60)) - 30;
        dy = int'($urandom_range(0, 60)) - 30;
      end
      2: begin
        dx = int'($urandom_range(0, 600)) - 300;
        dy = int'($urandom_range(0, 600)) - 300;
      end
      default: begin
        dx = int'($urandom_range(0, 8000)) - 4000;
        dy = int'($urandom_range(0, 8000)) - 4000;
      end
    endcase
    add_group(bx, jit);
    add_group(by, jit);
    add_group(bx + dx, jit);
    add_group(by + dy, jit);
  endtask

  // Mostly clean scans; the rest are pen-ups, cut-off scans and stray items.
  task automatic fill_random(int quota);
    int goal, pick, cut;
    goal = items_queued + quota;
    while (items_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        add_scan();
      end else if (pick < 85) begin
        push_item(1'b0, ADC_W'($urandom));
      end else if (pick < 95) begin
        cut = $urandom_range(1, 4 * GROUP_LEN - 1);
        repeat (cut) push_item(1'b1, ADC_W'($urandom));
        push_item(1'b0, ADC_W'($urandom));
      end else begin
        push_item(1'($urandom), ADC_W'($urandom));
      end
    end
  endtask

  // Waits until every item has had its transfer and every report has arrived,
  // then lets the pipeline empty of items that give no report.
  task automatic drain();
    while (sample_feed.size() != 0 || in_valid || pending_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_X_GAIN:    cal_x_gain   = val;
      CFG_Y_GAIN:    cal_y_gain   = val;
      CFG_X_OFFSET:  cal_x_offset = val;
      CFG_Y_OFFSET:  cal_y_offset = val;
      CFG_ERR_RANGE: agree_limit  = val[ERR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CFG_W-1:0] gx, logic [CFG_W-1:0] gy,
                           logic [CFG_W-1:0] ox, logic [CFG_W-1:0] oy,
                           logic [ERR_W-1:0] er);
    write_reg(CFG_X_GAIN, gx);
    write_reg(CFG_Y_GAIN, gy);
    write_reg(CFG_X_OFFSET, ox);
    write_reg(CFG_Y_OFFSET, oy);
    write_reg(CFG_ERR_RANGE, CFG_W'(er));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    reset_tracker();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: pen-up while idle, a scan cut off by a pen-up, a raw scan
    // built from full-scale extremes, then a pen-up while pressed.
    push_fixed(1'b0, ADC_W'(ADC_MAX), 1'b1, 1'b1);
    push_fixed(1'b1, ADC_W'(0), 1'b0, 1'b0);
    push_fixed(1'b1, ADC_W'(ADC_MAX), 1'b1, 1'b1);
    push_fixed(1'b0, ADC_W'(0), 1'b0, 1'b0);
    repeat (2) begin
      push_fixed(1'b1, ADC_W'(0), 1'b0, 1'b0);
      push_fixed(1'b1, ADC_W'(ADC_MAX), 1'b0, 1'b0);
      push_fixed(1'b1, ADC_W'(ADC_MAX), 1'b0, 1'b0);
      push_fixed(1'b1, ADC_W'(0), 1'b0, 1'b0);
      push_fixed(1'b1, ADC_W'(2048), 1'b0, 1'b0);
      repeat (GROUP_LEN) push_fixed(1'b1, ADC_W'(ADC_MAX), 1'b1, 1'b0);
    end
    push_fixed(1'b0, ADC_W'(0), 1'b0, 1'b0);
    drain();

    // Random phases under a range of calibrations, extremes included.
    configure(X_GAIN_RST, Y_GAIN_RST, X_OFFSET_RST, Y_OFFSET_RST, ERR_RST);
    fill_random(160);
    drain();
    configure(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, ERR_W'(ADC_MAX));
    fill_random(160);
    drain();
    configure(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, '0);
    fill_random(160);
    drain();
    configure(16'h4000, 16'h4000, 16'h0000, 16'h0000, ERR_W'(1));
    fill_random(160);
    drain();
    configure(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
              ERR_W'($urandom_range(0, 300)));
    fill_random(160);
    drain();
    configure(16'h0000, 16'hFFFF, CFG_W'($urandom), CFG_W'($urandom), ERR_W'(ADC_MAX));
    fill_random(160);
    drain();

    // Final stretch runs with no idling on either side.
    steady_tail = 1'b1;
    configure(CFG_W'($urandom), CFG_W'($urandom), X_OFFSET_RST, Y_OFFSET_RST, ERR_W'(60));
    fill_random(120);
    drain();

    if (errors == 0) begin
      $display("touch_sample_filter_and_press_tracker_core regression: pass");
    end else begin
      $display("touch_sample_filter_and_press_tracker_core regression: fail");
    end
    $finish;
  end

endmodule
